### rtl/frame_bitmap_allocator_macros.svh
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FBA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FBA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fba_pkg.sv
`default_nettype none

package fba_pkg;

    localparam int FRAME_W = 16;
    localparam int FIELD_W = 15;
    localparam int RUN_W   = 11;
    localparam int WIDX_W  = 11;
    localparam int BIT_W   = 5;
    localparam int CFG_W   = 16;

    localparam logic [2:0] OP_MARK_USED  = 3'd0;
    localparam logic [2:0] OP_MARK_FREE  = 3'd1;
    localparam logic [2:0] OP_TEST       = 3'd2;
    localparam logic [2:0] OP_FIND_FIRST = 3'd3;
    localparam logic [2:0] OP_FIND_RUN   = 3'd4;

    localparam logic CFG_FRAME_COUNT  = 1'b0;
    localparam logic CFG_SEARCH_START = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST  = 16'd32768;
    localparam logic [CFG_W-1:0] SEARCH_START_RST = 16'h0100;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_TEST_RD,
        ST_TEST_CHK,
        ST_FF_RD,
        ST_FF_CHK,
        ST_RUN_STEP,
        ST_RUN_RD,
        ST_RUN_LOAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             bit_val;
        logic             any_zero;
        logic [BIT_W-1:0] zero_idx;
    } word_stat_t;

endpackage

`default_nettype wire

### rtl/fba_bitmap_ram.sv
`default_nettype none

module fba_bitmap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/fba_word_unit.sv
`default_nettype none

module fba_word_unit (
    input  wire logic [31:0]             word,
    input  wire logic [fba_pkg::BIT_W-1:0] bit_idx,
    input  wire logic                    set_val,
    output logic      [31:0]             wr_word,
    output fba_pkg::word_stat_t          stat
);

    always_comb
    begin
        logic [fba_pkg::BIT_W-1:0] idx;
        idx = '0;
        // Walk downwards so that the lowest clear bit is the one kept.
        for (int b = 31; b >= 0; b--)
        begin
            if (!word[b])
            begin
                idx = fba_pkg::BIT_W'(b);
            end
        end
        stat.zero_idx = idx;
        stat.any_zero = ~&word;
        stat.bit_val  = word[bit_idx];
        wr_word          = word;
        wr_word[bit_idx] = set_val;
    end

endmodule

`default_nettype wire

### rtl/fba_seq.sv
`default_nettype none
`include "frame_bitmap_allocator_macros.svh"

module fba_seq #(
    parameter int MAX_FRAMES = 32768,
    parameter int MAX_RUN    = 1024,
    parameter int WORDS      = 1024,
    parameter int AW         = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [fba_pkg::CFG_W-1:0]     frame_count,
    input  wire logic [fba_pkg::CFG_W-1:0]     search_start,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    operation,
    input  wire logic [fba_pkg::FIELD_W-1:0]   frame_number,
    input  wire logic [fba_pkg::RUN_W-1:0]     run_length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic      [fba_pkg::FIELD_W-1:0]   result_frame,
    output logic                               is_used,
    output logic                               ram_we,
    output logic                               ram_re,
    output logic      [AW-1:0]                 ram_addr,
    output logic      [31:0]                   ram_wdata,
    input  wire logic [31:0]                   ram_rdata,
    output logic      [31:0]                   wu_word,
    output logic      [fba_pkg::BIT_W-1:0]     wu_bit,
    output logic                               wu_set,
    input  wire logic [31:0]                   wu_wr_word,
    input  wire fba_pkg::word_stat_t           wu_stat
);

    fba_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                 clr_reg, clr_next;
    logic [fba_pkg::FIELD_W-1:0]   fr_reg, fr_next;
    logic [fba_pkg::RUN_W-1:0]     n_reg, n_next;
    logic [fba_pkg::FRAME_W-1:0]   lim_reg, lim_next;
    logic                          set_reg, set_next;
    logic [fba_pkg::FRAME_W-1:0]   cur_reg, cur_next;
    logic [fba_pkg::RUN_W-1:0]     j_reg, j_next;
    logic [fba_pkg::WIDX_W-1:0]    w_reg, w_next;
    logic [31:0]                   word_reg, word_next;
    logic [fba_pkg::WIDX_W-1:0]    tag_reg, tag_next;
    logic                          tag_ok_reg, tag_ok_next;
    logic                          p_found_reg, p_found_next;
    logic [fba_pkg::FIELD_W-1:0]   p_frame_reg, p_frame_next;
    logic                          p_used_reg, p_used_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg, found_next;
    logic [fba_pkg::FIELD_W-1:0]   frame_reg, frame_next;
    logic                          used_reg, used_next;

    logic [fba_pkg::WIDX_W-1:0]    sel_widx;
    logic [31:0]                   widx_ext;
    logic [fba_pkg::FRAME_W-1:0]   run_f;

    assign run_f    = cur_reg + fba_pkg::FRAME_W'(j_reg);
    assign widx_ext = 32'(sel_widx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fba_pkg::ST_CLEAR;
            clr_reg       <= '0;
            tag_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            tag_ok_reg    <= tag_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_reg      <= fr_next;
        n_reg       <= n_next;
        lim_reg     <= lim_next;
        set_reg     <= set_next;
        cur_reg     <= cur_next;
        j_reg       <= j_next;
        w_reg       <= w_next;
        word_reg    <= word_next;
        tag_reg     <= tag_next;
        p_found_reg <= p_found_next;
        p_frame_reg <= p_frame_next;
        p_used_reg  <= p_used_next;
        found_reg   <= found_next;
        frame_reg   <= frame_next;
        used_reg    <= used_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        fr_next        = fr_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        set_next       = set_reg;
        cur_next       = cur_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        word_next      = word_reg;
        tag_next       = tag_reg;
        tag_ok_next    = tag_ok_reg;
        p_found_next   = p_found_reg;
        p_frame_next   = p_frame_reg;
        p_used_next    = p_used_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        frame_next     = frame_reg;
        used_next      = used_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = '0;
        sel_widx       = {1'b0, fr_reg[fba_pkg::FIELD_W-1:fba_pkg::BIT_W]};
        wu_word        = ram_rdata;
        wu_bit         = fr_reg[fba_pkg::BIT_W-1:0];
        wu_set         = set_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fr_next      = frame_number;
                    n_next       = run_length;
                    lim_next     = (32'(frame_count) < MAX_FRAMES) ? frame_count
                                                                   : fba_pkg::FRAME_W'(MAX_FRAMES);
                    set_next     = (operation == fba_pkg::OP_MARK_USED);
                    tag_ok_next  = 1'b0;
                    p_found_next = 1'b0;
                    p_frame_next = '0;
                    p_used_next  = 1'b0;
                    cur_next     = search_start;
                    j_next       = '0;
                    w_next       = search_start[fba_pkg::CFG_W-1:fba_pkg::BIT_W];
                    state_next   = fba_pkg::ST_DONE;
                    case (operation)
                        fba_pkg::OP_MARK_USED, fba_pkg::OP_MARK_FREE:
                        begin
                            if (32'(frame_number) < MAX_FRAMES)
                            begin
                                state_next = fba_pkg::ST_MARK_RD;
                            end
                        end
                        fba_pkg::OP_TEST:
                        begin
                            // Frames beyond the bitmap always read as used.
                            if (32'(frame_number) < MAX_FRAMES)
                            begin
                                state_next = fba_pkg::ST_TEST_RD;
                            end
                            else
                            begin
                                p_used_next = 1'b1;
                            end
                        end
                        fba_pkg::OP_FIND_FIRST:
                        begin
                            state_next = fba_pkg::ST_FF_RD;
                        end
                        fba_pkg::OP_FIND_RUN:
                        begin
                            if (32'(run_length) <= MAX_RUN)
                            begin
                                state_next = fba_pkg::ST_RUN_STEP;
                            end
                        end
                        default:
                        begin
                            state_next = fba_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            fba_pkg::ST_MARK_RD:
            begin
                ram_re     = 1'b1;
                state_next = fba_pkg::ST_MARK_WR;
            end
            fba_pkg::ST_MARK_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = wu_wr_word;
                state_next = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_TEST_RD:
            begin
                ram_re     = 1'b1;
                state_next = fba_pkg::ST_TEST_CHK;
            end
            fba_pkg::ST_TEST_CHK:
            begin
                p_used_next = wu_stat.bit_val;
                state_next  = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_FF_RD:
            begin
                sel_widx = w_reg;
                if (w_reg >= lim_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_W])
                begin
                    state_next = fba_pkg::ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = fba_pkg::ST_FF_CHK;
                end
            end
            fba_pkg::ST_FF_CHK:
            begin
                sel_widx = w_reg;
                if (wu_stat.any_zero)
                begin
                    p_found_next = 1'b1;
                    p_frame_next = {w_reg[fba_pkg::FIELD_W-fba_pkg::BIT_W-1:0],
                                    wu_stat.zero_idx};
                    state_next   = fba_pkg::ST_DONE;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = fba_pkg::ST_FF_RD;
                end
            end
            fba_pkg::ST_RUN_STEP:
            begin
                wu_word  = word_reg;
                wu_bit   = run_f[fba_pkg::BIT_W-1:0];
                sel_widx = run_f[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
                // A zero-length run still needs a candidate below the limit.
                if ((j_reg == n_reg) && ((n_reg != '0) || (run_f < lim_reg)))
                begin
                    p_found_next = 1'b1;
                    p_frame_next = cur_reg[fba_pkg::FIELD_W-1:0];
                    state_next   = fba_pkg::ST_DONE;
                end
                else if (run_f >= lim_reg)
                begin
                    state_next = fba_pkg::ST_DONE;
                end
                else if (!tag_ok_reg ||
                         (tag_reg != run_f[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]))
                begin
                    state_next = fba_pkg::ST_RUN_RD;
                end
                else if (wu_stat.bit_val)
                begin
                    cur_next = run_f + 1'b1;
                    j_next   = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            fba_pkg::ST_RUN_RD:
            begin
                sel_widx   = run_f[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
                ram_re     = 1'b1;
                state_next = fba_pkg::ST_RUN_LOAD;
            end
            fba_pkg::ST_RUN_LOAD:
            begin
                word_next   = ram_rdata;
                tag_next    = run_f[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
                tag_ok_next = 1'b1;
                state_next  = fba_pkg::ST_RUN_STEP;
            end
            fba_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = p_found_reg;
                    frame_next     = p_frame_reg;
                    used_next      = p_used_reg;
                    state_next     = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    assign ram_addr     = (state_reg == fba_pkg::ST_CLEAR) ? clr_reg : widx_ext[AW-1:0];
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_frame = frame_reg;
    assign is_used      = used_reg;

    `FBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
        "ready stayed high after a word was accepted")
    `FBA_ASSERT_IMPL(a_clear_writes_zero, clk, rst_n, state_reg == fba_pkg::ST_CLEAR,
        ram_we && (ram_wdata == '0), "clearing pass did not write a zero word")
    `FBA_ASSERT_IMPL(a_write_source, clk, rst_n, ram_we,
        (state_reg == fba_pkg::ST_CLEAR) || (state_reg == fba_pkg::ST_MARK_WR),
        "bitmap written outside the clearing pass or a mark")
    `FBA_ASSERT_IMPL(a_result_kind, clk, rst_n, out_valid_reg, !(found_reg && used_reg),
        "result reports both a search hit and a used frame")

endmodule

`default_nettype wire

### rtl/frame_bitmap_allocator.sv
// Mark reads the word and writes it back; test reads the word and checks the bit.
// Find first free reads and checks words in turn up to a clear bit or the limit.
// Run search steps frame by frame, fetching each bitmap word it enters.
// One request at a time through a single-port bitmap memory with registered read.
// Reset: asynchronous, active low; a clearing pass writes zero to each of the
// (MAX_FRAMES+31)/32 bitmap words before the first request is taken.
`default_nettype none

module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 32768,
    parameter int MAX_RUN    = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic                        cfg_index,
    input  wire logic [fba_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  operation,
    input  wire logic [fba_pkg::FIELD_W-1:0] frame_number,
    input  wire logic [fba_pkg::RUN_W-1:0]   run_length,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             found,
    output logic      [fba_pkg::FIELD_W-1:0] result_frame,
    output logic                             is_used
);

    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [fba_pkg::CFG_W-1:0] frame_count_reg;
    logic [fba_pkg::CFG_W-1:0] search_start_reg;

    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_addr;
    logic [31:0]               ram_wdata;
    logic [31:0]               ram_rdata;
    logic [31:0]               wu_word;
    logic [fba_pkg::BIT_W-1:0] wu_bit;
    logic                      wu_set;
    logic [31:0]               wu_wr_word;
    fba_pkg::word_stat_t       wu_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= fba_pkg::FRAME_COUNT_RST;
            search_start_reg <= fba_pkg::SEARCH_START_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fba_pkg::CFG_FRAME_COUNT:  frame_count_reg  <= cfg_data;
                fba_pkg::CFG_SEARCH_START: search_start_reg <= cfg_data;
                default:                   frame_count_reg  <= frame_count_reg;
            endcase
        end
    end

    fba_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fba_word_unit u_word_unit (
        .word    (wu_word),
        .bit_idx (wu_bit),
        .set_val (wu_set),
        .wr_word (wu_wr_word),
        .stat    (wu_stat)
    );

    fba_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_RUN    (MAX_RUN),
        .WORDS      (WORDS),
        .AW         (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_count  (frame_count_reg),
        .search_start (search_start_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .frame_number (frame_number),
        .run_length   (run_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_frame (result_frame),
        .is_used      (is_used),
        .ram_we       (ram_we),
        .ram_re       (ram_re),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .wu_word      (wu_word),
        .wu_bit       (wu_bit),
        .wu_set       (wu_set),
        .wu_wr_word   (wu_wr_word),
        .wu_stat      (wu_stat)
    );

endmodule

`default_nettype wire
